[sv/rpwd_pkg.sv]
package rpwd_pkg;

	localparam int FRAME_BITS = 24;
	localparam int TIMER_BITS = 16;
	localparam int POS_BITS   = 5;
	localparam int CFG_BITS   = 16;
	localparam int REQ_BITS   = 2;
	localparam int IDX_BITS   = 2;

	localparam logic [CFG_BITS-1:0] PREAMBLE_MIN_RST = CFG_BITS'(9200);
	localparam logic [CFG_BITS-1:0] ONE_MIN_RST      = CFG_BITS'(200);
	localparam logic [CFG_BITS-1:0] ONE_MAX_RST      = CFG_BITS'(400);

	localparam logic [POS_BITS-1:0] POS_RST = POS_BITS'(FRAME_BITS - 1);

	typedef enum logic [REQ_BITS-1:0] {
		REQ_EDGE    = 2'd0,
		REQ_READ    = 2'd1,
		REQ_DISCARD = 2'd2
	} req_code_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_PREAMBLE_MIN = 2'd0,
		REG_ONE_MIN      = 2'd1,
		REG_ONE_MAX      = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] preamble_min;
		logic [CFG_BITS-1:0] one_min;
		logic [CFG_BITS-1:0] one_max;
	} rpwd_cfg_t;

	typedef struct packed {
		logic                  valid;
		logic [FRAME_BITS-1:0] code;
		logic                  status;
	} rpwd_result_t;

endpackage

[sv/rpwd_cfg_regs.sv]
module rpwd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rpwd_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [rpwd_pkg::CFG_BITS-1:0]     cfg_data,
	output rpwd_pkg::rpwd_cfg_t               cfg
);
	import rpwd_pkg::*;

	rpwd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_min <= PREAMBLE_MIN_RST;
			cfg_q.one_min      <= ONE_MIN_RST;
			cfg_q.one_max      <= ONE_MAX_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_PREAMBLE_MIN: cfg_q.preamble_min <= cfg_data;
				REG_ONE_MIN:      cfg_q.one_min      <= cfg_data;
				REG_ONE_MAX:      cfg_q.one_max      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/rpwd_decode.sv]
module rpwd_decode (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic [rpwd_pkg::REQ_BITS-1:0]       req,
	input  logic                                level,
	input  logic [rpwd_pkg::TIMER_BITS-1:0]     ts,
	input  rpwd_pkg::rpwd_cfg_t                 cfg,
	output rpwd_pkg::rpwd_result_t              res
);
	import rpwd_pkg::*;

	logic [POS_BITS-1:0]   bit_pos_q, bit_pos_d;
	logic                  ready_q, ready_d;
	logic                  armed_q, armed_d;
	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic [TIMER_BITS-1:0] fall_q, fall_d;

	logic [TIMER_BITS-1:0] low_time;
	logic                  is_one;

	assign low_time = ts - fall_q;
	assign is_one   = (TIMER_BITS'(cfg.one_max) > low_time) &&
	                  (low_time >= TIMER_BITS'(cfg.one_min));

	always_comb begin
		bit_pos_d  = bit_pos_q;
		ready_d    = ready_q;
		armed_d    = armed_q;
		shift_d    = shift_q;
		fall_d     = fall_q;
		res.valid  = 1'b0;
		res.code   = '0;
		res.status = 1'b1;
		unique case (req_code_t'(req))
			REQ_EDGE: begin
				if (!ready_q) begin
					if (!level) begin
						fall_d = ts;
					end else if (armed_q) begin
						ready_d = (bit_pos_q == '0);
						for (int i = 0; i < FRAME_BITS; i++) begin
							if (is_one && bit_pos_q == POS_BITS'(i))
								shift_d[i] = 1'b1;
						end
						if (bit_pos_q != '0)
							bit_pos_d = bit_pos_q - 1'b1;
					end else begin
						bit_pos_d = POS_RST;
						ready_d   = 1'b0;
						shift_d   = '0;
						fall_d    = '0;
						armed_d   = (low_time >= TIMER_BITS'(cfg.preamble_min));
					end
				end
			end
			REQ_READ: begin
				res.valid = 1'b1;
				if (ready_q) begin
					res.code   = shift_q;
					res.status = 1'b0;
					bit_pos_d  = POS_RST;
					ready_d    = 1'b0;
					armed_d    = 1'b0;
					shift_d    = '0;
					fall_d     = '0;
				end
			end
			REQ_DISCARD: begin
				bit_pos_d = POS_RST;
				ready_d   = 1'b0;
				armed_d   = 1'b0;
				shift_d   = '0;
				fall_d    = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= POS_RST;
			ready_q   <= 1'b0;
			armed_q   <= 1'b0;
			shift_q   <= '0;
			fall_q    <= '0;
		end else if (fire) begin
			bit_pos_q <= bit_pos_d;
			ready_q   <= ready_d;
			armed_q   <= armed_d;
			shift_q   <= shift_d;
			fall_q    <= fall_d;
		end
	end

endmodule

[sv/rf_remote_pulse_width_decoder_core.sv]
// Remote frame decoder: pulse widths on a pin become a 24-bit code.
// Input channel (in_valid / in_stall) carries one word per request: a pin
// edge (req_type 0, with pin_level and timestamp), a read of the decoded
// code (1) or a discard of the frame (2). Code 3 is dropped.
// Only a read gives an output word on code_out / read_status
// (out_valid / out_stall); read_status 1 means no complete frame yet.
// Threshold registers are written through cfg_we / cfg_index / cfg_data.
// The user must write them only while no request is in flight; the
// block itself does not enforce this. A word taken into the input stage
// is decoded there; a read result is registered and shows on out_valid.
// Throughput: one word per cycle while in_stall is low; the decode stage
// updates its frame state each time a word fires.
// A stalled output holds its word; the input stalls only when a read sits
// in the input stage and the output register is full and stalled.
// Reset clears the frame state and loads the default thresholds; the
// block takes words right after reset.
module rf_remote_pulse_width_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rpwd_pkg::IDX_BITS-1:0]       cfg_index,
	input  logic [rpwd_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rpwd_pkg::REQ_BITS-1:0]       req_type,
	input  logic                                pin_level,
	input  logic [rpwd_pkg::TIMER_BITS-1:0]     timestamp,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rpwd_pkg::FRAME_BITS-1:0]     code_out,
	output logic                                read_status
);
	import rpwd_pkg::*;

	rpwd_cfg_t    cfg;
	rpwd_result_t res;

	logic                  valid_s1;
	logic [REQ_BITS-1:0]   req_s1;
	logic                  level_s1;
	logic [TIMER_BITS-1:0] ts_s1;

	logic                  out_valid_q;
	logic [FRAME_BITS-1:0] code_q;
	logic                  status_q;

	logic out_free;
	logic fire;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && res.valid && !out_free;
	assign fire     = valid_s1 && !in_stall;

	rpwd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rpwd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.level  (level_s1),
		.ts     (ts_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1   <= req_type;
			level_s1 <= pin_level;
			ts_s1    <= timestamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			code_q   <= res.code;
			status_q <= res.status;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_out    = code_q;
	assign read_status = status_q;

endmodule

[tb/sv/testbench.sv]
module testbench;
	import rpwd_pkg::*;

	localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [FRAME_BITS-1:0] code;
		logic                  status;
	} read_answer_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IDX_BITS-1:0]   cfg_index = REG_PREAMBLE_MIN;
	logic [CFG_BITS-1:0]   cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [REQ_BITS-1:0]   req_type = REQ_EDGE;
	logic                  pin_level = 1'b0;
	logic [TIMER_BITS-1:0] timestamp = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [FRAME_BITS-1:0] code_out;
	logic                  read_status;

	logic [CFG_BITS-1:0]   thr_preamble = PREAMBLE_MIN_RST;
	logic [CFG_BITS-1:0]   thr_one_min = ONE_MIN_RST;
	logic [CFG_BITS-1:0]   thr_one_max = ONE_MAX_RST;

	logic [POS_BITS-1:0]   trk_pos = POS_RST;
	logic                  trk_ready = 1'b0;
	logic                  trk_armed = 1'b0;
	logic [FRAME_BITS-1:0] trk_code = '0;
	logic [TIMER_BITS-1:0] trk_fall = '0;
	logic [TIMER_BITS-1:0] trk_low = '0;

	read_answer_t          reads_due[$];
	read_answer_t          want;
	logic [TIMER_BITS-1:0] now_ts = '0;
	int                    items_sent = 0;
	int                    errors = 0;
	int                    rx_hold = 0;
	logic                  tx_idle = 1'b1;
	logic                  rx_idle = 1'b1;

	rf_remote_pulse_width_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.pin_level   (pin_level),
		.timestamp   (timestamp),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_out    (code_out),
		.read_status (read_status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void clear_frame();
		trk_pos = POS_RST;
		trk_ready = 1'b0;
		trk_armed = 1'b0;
		trk_code = '0;
		trk_fall = '0;
	endfunction

	function automatic void track_decoder(input logic [REQ_BITS-1:0] rq, input logic lvl,
			input logic [TIMER_BITS-1:0] ts);
		read_answer_t ans;
		case (rq)
		REQ_EDGE: begin
			if (!trk_ready) begin
				if (!lvl) begin
					trk_fall = ts;
				end else begin
					trk_low = ts - trk_fall;
					if (trk_armed) begin
						trk_ready = (trk_pos == 0);
						if (trk_low >= thr_one_min && trk_low < thr_one_max)
							trk_code[trk_pos] = 1'b1;
						if (trk_pos != 0)
							trk_pos = trk_pos - 1'b1;
					end else begin
						clear_frame();
						trk_armed = (trk_low >= thr_preamble);
					end
				end
			end
		end
		REQ_READ: begin
			ans.code = trk_ready ? trk_code : '0;
			ans.status = !trk_ready;
			reads_due.push_back(ans);
			if (trk_ready)
				clear_frame();
		end
		REQ_DISCARD: clear_frame();
		default: ;
		endcase
	endfunction

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endfunction

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else begin
			out_stall <= rx_idle && ($urandom_range(99) < 36);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (reads_due.size() == 0) begin
				flag_error($sformatf("unexpected word code %h status %b", code_out, read_status));
			end else begin
				want = reads_due.pop_front();
				if (code_out !== want.code || read_status !== want.status)
					flag_error($sformatf("code exp %h got %h, status exp %b got %b",
						want.code, code_out, want.status, read_status));
			end
		end
	end

	task automatic send_word(input logic [REQ_BITS-1:0] rq, input logic lvl,
			input logic [TIMER_BITS-1:0] ts);
		if (tx_idle) begin
			while ($urandom_range(99) < 36) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= rq;
		pin_level <= lvl;
		timestamp <= ts;
		do
			@(posedge clk);
		while (in_stall);
		track_decoder(rq, lvl, ts);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (reads_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_thresholds(input logic [CFG_BITS-1:0] pre, lo, hi);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_PREAMBLE_MIN;
		cfg_data <= pre;
		@(negedge clk);
		cfg_index <= REG_ONE_MIN;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= REG_ONE_MAX;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		thr_preamble = pre;
		thr_one_min = lo;
		thr_one_max = hi;
	endtask

	function automatic logic [TIMER_BITS-1:0] bit_width(input logic b);
		int lo, hi;
		lo = thr_one_min;
		hi = thr_one_max;
		case ($urandom_range(3))
		0: return b ? TIMER_BITS'(lo) : TIMER_BITS'(lo - 1);
		1: return b ? TIMER_BITS'(hi - 1) : TIMER_BITS'(hi);
		2: return b ? TIMER_BITS'($urandom_range(lo, hi - 1)) : TIMER_BITS'($urandom);
		default: return b ? TIMER_BITS'($urandom_range(lo, hi - 1)) :
			TIMER_BITS'($urandom_range(hi, 65535));
		endcase
	endfunction

	function automatic logic [FRAME_BITS-1:0] random_code();
		case ($urandom_range(9))
		0: return '1;
		1: return '0;
		default: return FRAME_BITS'($urandom);
		endcase
	endfunction

	task automatic pulse(input logic [TIMER_BITS-1:0] width);
		send_word(REQ_EDGE, 1'b0, now_ts);
		now_ts = now_ts + width;
		send_word(REQ_EDGE, 1'b1, now_ts);
		now_ts = now_ts + TIMER_BITS'($urandom_range(1, 600));
	endtask

	task automatic send_frame(input logic [FRAME_BITS-1:0] code, input int nbits);
		if ($urandom_range(1))
			pulse(thr_preamble);
		else
			pulse(TIMER_BITS'($urandom_range(thr_preamble, 65535)));
		for (int i = FRAME_BITS - 1; i > FRAME_BITS - 1 - nbits; i--)
			pulse(bit_width(code[i]));
	endtask

	task automatic noise(input int count);
		repeat (count)
			send_word(REQ_BITS'($urandom), 1'($urandom), TIMER_BITS'($urandom));
	endtask

	task automatic random_traffic(input int count);
		int stop_at, pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_frame(random_code(), FRAME_BITS);
				if ($urandom_range(3) == 0)
					noise($urandom_range(1, 3));
				send_word($urandom_range(4) == 0 ? REQ_DISCARD : REQ_READ, 1'b0, now_ts);
				if ($urandom_range(3) == 0)
					send_word(REQ_READ, 1'b1, now_ts);
			end else if (pick < 80) begin
				send_frame(random_code(), $urandom_range(0, FRAME_BITS - 1));
				case ($urandom_range(2))
				0: send_word(REQ_READ, 1'b0, now_ts);
				1: send_word(REQ_DISCARD, 1'b0, now_ts);
				default: ;
				endcase
			end else begin
				noise($urandom_range(1, 8));
			end
		end
	endtask

	task automatic test_requests();
		send_word(REQ_UNUSED, 1'b1, 16'hffff);
		send_word(REQ_READ, 1'b0, 16'h0000);
		send_word(REQ_DISCARD, 1'b1, 16'h0000);
		send_word(REQ_EDGE, 1'b1, 16'd100);
		send_word(REQ_EDGE, 1'b0, 16'hff00);
		send_word(REQ_EDGE, 1'b1, 16'h2300);
		send_word(REQ_EDGE, 1'b0, 16'd0);
		send_word(REQ_EDGE, 1'b1, 16'd200);
		send_word(REQ_EDGE, 1'b0, 16'd1000);
		send_word(REQ_EDGE, 1'b1, 16'd1400);
		send_word(REQ_EDGE, 1'b0, 16'd2000);
		send_word(REQ_EDGE, 1'b1, 16'd2199);
		send_word(REQ_READ, 1'b1, 16'hffff);
		send_word(REQ_EDGE, 1'b0, 16'd3000);
		send_word(REQ_EDGE, 1'b1, 16'd3399);
		send_word(REQ_DISCARD, 1'b0, 16'd0);
		send_word(REQ_READ, 1'b0, 16'd0);
		send_word(REQ_EDGE, 1'b0, 16'd0);
		send_word(REQ_EDGE, 1'b1, 16'd9199);
		send_word(REQ_EDGE, 1'b0, 16'd10000);
		send_word(REQ_EDGE, 1'b1, 16'd19200);
		send_word(REQ_UNUSED, 1'b0, 16'd0);
		send_word(REQ_READ, 1'b0, 16'd0);
		drain();
	endtask

	task automatic test_steady();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		random_traffic(100);
		drain();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_thresholds();
		logic [CFG_BITS-1:0] lo, hi;
		set_thresholds(16'd0, 16'd0, 16'hffff);
		random_traffic(100);
		set_thresholds(16'hffff, 16'd1000, 16'd2000);
		random_traffic(100);
		set_thresholds(16'd500, 16'd300, 16'd300);
		random_traffic(80);
		set_thresholds(16'd500, 16'd2000, 16'd100);
		random_traffic(80);
		set_thresholds(16'd0, 16'hffff, 16'hffff);
		random_traffic(40);
		repeat (3) begin
			lo = CFG_BITS'($urandom_range(0, 4000));
			hi = lo + CFG_BITS'($urandom_range(1, 4000));
			set_thresholds(CFG_BITS'($urandom), lo, hi);
			random_traffic(70);
		end
		set_thresholds(PREAMBLE_MIN_RST, ONE_MIN_RST, ONE_MAX_RST);
		random_traffic(90);
		drain();
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_hold = 150;
		send_frame(random_code(), FRAME_BITS);
		repeat (40)
			send_word(REQ_READ, 1'b0, now_ts);
		drain();
		tx_idle = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_requests();
		test_steady();
		test_thresholds();
		test_backpressure();
		drain();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
